[src/wheel30_segmented_prime_sieve_unit_macros.svh]
// Assertion macros of the wheel-30 sieve RTL, used by the datapath.
// Included by wsieve_dp, which checks its own logic; needs clock and reset in scope.
`ifndef WHEEL30_SEGMENTED_PRIME_SIEVE_UNIT_MACROS_SVH
`define WHEEL30_SEGMENTED_PRIME_SIEVE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define WSIEVE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wsieve check failed");

// next-cycle implication, checked out of reset
`define WSIEVE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wsieve check failed");

`endif

[src/wsieve_pkg.sv]
// Shared types, constants and wheel tables of the wheel-30 sieve.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package wsieve_pkg;

   localparam int unsigned LIMIT_W      = 20;
   localparam int unsigned P_W          = 10;     // base primes stay below 1024
   localparam int unsigned SQ_W         = 20;
   localparam int unsigned M_W          = 21;     // multiple may overshoot the limit
   localparam int unsigned BLKQ_W       = 16;     // quotient / block count width
   localparam int unsigned PB_W         = 6;      // block of a base prime
   localparam int unsigned PROD_W       = LIMIT_W + BLKQ_W;
   localparam int unsigned LIMIT_BLOCKS = 32768;  // cap on the store depth in blocks
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 20'd983039;
   // floor(2^20/30); quotient may come out one low, fixed by one subtract
   localparam logic [BLKQ_W-1:0] RECIP30 = 16'd34952;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_RANGE   = 2'd1;
   localparam logic [1:0] ST_NOBUILD = 2'd2;

   // divider operand select
   localparam logic [1:0] DIV_NUM  = 2'd0;
   localparam logic [1:0] DIV_LIM  = 2'd1;
   localparam logic [1:0] DIV_MULT = 2'd2;

   // memory read address select
   localparam logic RD_Q  = 1'b0;
   localparam logic RD_PB = 1'b1;

   localparam logic MODE_BUILD = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [3:0] SLOT_NONE = 4'd8;

   typedef struct packed {
      logic       req_load;
      logic [1:0] div_sel;
      logic       size_load;
      logic       fill_en;
      logic       prime_init;
      logic       prime_load;
      logic       prime_next;
      logic       mult_init;
      logic       mult_clear;
      logic       rd_sel;
      logic       build_done;
      logic       rsp_load;
      logic       rsp_build;
   } wsieve_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic sq_over;
      logic prime_bit;
      logic m_over;
      logic rsp_free;
   } wsieve_stat_type;

   // wheel gaps 6,4,2,4,2,4,6,2
   function automatic logic [2:0] gap_of(input logic [2:0] g);
      logic [2:0] v;
      case (g)
         3'd0: v = 3'd6;
         3'd1: v = 3'd4;
         3'd2: v = 3'd2;
         3'd3: v = 3'd4;
         3'd4: v = 3'd2;
         3'd5: v = 3'd4;
         3'd6: v = 3'd6;
         default: v = 3'd2;
      endcase
      return v;
   endfunction

   // residues coprime to 30
   function automatic logic [4:0] res_of(input logic [2:0] j);
      logic [4:0] v;
      case (j)
         3'd0: v = 5'd1;
         3'd1: v = 5'd7;
         3'd2: v = 5'd11;
         3'd3: v = 5'd13;
         3'd4: v = 5'd17;
         3'd5: v = 5'd19;
         3'd6: v = 5'd23;
         default: v = 5'd29;
      endcase
      return v;
   endfunction

   // residue mod 30 to wheel bit, SLOT_NONE if not coprime to 30
   function automatic logic [3:0] slot_of(input logic [4:0] r);
      logic [3:0] v;
      case (r)
         5'd1:  v = 4'd0;
         5'd7:  v = 4'd1;
         5'd11: v = 4'd2;
         5'd13: v = 4'd3;
         5'd17: v = 4'd4;
         5'd19: v = 4'd5;
         5'd23: v = 4'd6;
         5'd29: v = 4'd7;
         default: v = SLOT_NONE;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

[src/wsieve_ctrl.sv]
// Sequencer of the wheel-30 sieve: query lookup and the build walk.
// Depends on wsieve_pkg; drives wsieve_dp through command words.
`default_nettype none

module wsieve_ctrl
   import wsieve_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_mode,
   output logic                 req_stall,
   input  wsieve_stat_type      stat,
   output wsieve_cmd_type       cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_QDIVA  = 4'd1;
   localparam logic [3:0] S_QDIVB  = 4'd2;
   localparam logic [3:0] S_QREAD  = 4'd3;
   localparam logic [3:0] S_QRESP  = 4'd4;
   localparam logic [3:0] S_BDIVA  = 4'd5;
   localparam logic [3:0] S_BDIVB  = 4'd6;
   localparam logic [3:0] S_BSIZE  = 4'd7;
   localparam logic [3:0] S_BFILL  = 4'd8;
   localparam logic [3:0] S_BPSQ   = 4'd9;
   localparam logic [3:0] S_BPCHK  = 4'd10;
   localparam logic [3:0] S_BMDIVA = 4'd11;
   localparam logic [3:0] S_BMDIVB = 4'd12;
   localparam logic [3:0] S_BMRD   = 4'd13;
   localparam logic [3:0] S_BMWR   = 4'd14;
   localparam logic [3:0] S_BRESP  = 4'd15;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // take a word only between items
   assign req_stall = (state_ff != S_IDLE);

   // next state and command word
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DIV_NUM;
      cmd.rd_sel  = RD_Q;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in = (req_mode == MODE_BUILD) ? S_BDIVA : S_QDIVA;
            end
         end
         S_QDIVA: state_in = S_QDIVB;
         S_QDIVB: state_in = S_QREAD;
         S_QREAD: state_in = S_QRESP;
         S_QRESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_BDIVA: begin
            cmd.div_sel = DIV_LIM;
            state_in = S_BDIVB;
         end
         S_BDIVB: begin
            cmd.div_sel = DIV_LIM;
            state_in = S_BSIZE;
         end
         S_BSIZE: begin
            cmd.size_load = 1'b1;
            state_in = S_BFILL;
         end
         S_BFILL: begin
            cmd.fill_en = 1'b1;
            if (stat.fill_last) begin
               cmd.prime_init = 1'b1;
               state_in = S_BPSQ;
            end
         end
         S_BPSQ: begin
            cmd.prime_load = 1'b1;
            cmd.rd_sel = RD_PB;
            state_in = S_BPCHK;
         end
         S_BPCHK: begin
            if (stat.sq_over) begin
               cmd.build_done = 1'b1;
               state_in = S_BRESP;
            end else if (!stat.prime_bit) begin
               cmd.prime_next = 1'b1;
               state_in = S_BPSQ;
            end else begin
               cmd.mult_init = 1'b1;
               state_in = S_BMDIVA;
            end
         end
         S_BMDIVA: begin
            cmd.div_sel = DIV_MULT;
            if (stat.m_over) begin
               cmd.prime_next = 1'b1;
               state_in = S_BPSQ;
            end else begin
               state_in = S_BMDIVB;
            end
         end
         S_BMDIVB: begin
            cmd.div_sel = DIV_MULT;
            state_in = S_BMRD;
         end
         S_BMRD: begin
            cmd.div_sel = DIV_MULT;
            state_in = S_BMWR;
         end
         S_BMWR: begin
            cmd.div_sel = DIV_MULT;
            cmd.mult_clear = 1'b1;
            state_in = S_BMDIVA;
         end
         S_BRESP: begin
            cmd.rsp_build = 1'b1;
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[src/wsieve_dp.sv]
// Datapath of the wheel-30 sieve: wheel store, divide-by-30 unit, walk registers.
// Depends on wsieve_pkg and the assertion macros; driven by wsieve_ctrl.
`default_nettype none
`include "wheel30_segmented_prime_sieve_unit_macros.svh"

module wsieve_dp
   import wsieve_pkg::*;
#(
   parameter int unsigned WHEEL_BLOCKS = 32768
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [LIMIT_W-1:0] req_number,
   input  wire logic               csr_wr_en,
   input  wire logic [LIMIT_W-1:0] csr_wr_data,
   input  wsieve_cmd_type          cmd,
   output wsieve_stat_type         stat,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_prime,
   output logic [1:0]              rsp_status
);

   localparam int unsigned EFF_BLOCKS =
      (WHEEL_BLOCKS < LIMIT_BLOCKS) ? WHEEL_BLOCKS : LIMIT_BLOCKS;
   localparam int unsigned ADDR_W = (EFF_BLOCKS > 1) ? $clog2(EFF_BLOCKS) : 1;
   localparam logic [BLKQ_W-1:0] EFF_CNT = BLKQ_W'(EFF_BLOCKS);

   // wheel store, one byte per 30 numbers
   logic [7:0] wheel_mem [EFF_BLOCKS];

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [LIMIT_W-1:0] num_ff, num_in;
   logic [LIMIT_W-1:0] built_limit_ff, built_limit_in;
   logic               built_flag_ff, built_flag_in;
   logic [LIMIT_W-1:0] lim_ff, lim_in;
   logic [BLKQ_W-1:0]  nblk_ff, nblk_in;
   logic [BLKQ_W-1:0]  fill_ff, fill_in;
   logic [PB_W-1:0]    pb_ff, pb_in;
   logic [2:0]         pj_ff, pj_in;
   logic [P_W-1:0]     p_ff, p_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [M_W-1:0]     m_ff, m_in;
   logic [2:0]         g_ff, g_in;
   logic [LIMIT_W-1:0] x_ff, x_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [BLKQ_W-1:0]  q_ff, q_in;
   logic [4:0]         r_ff, r_in;
   logic [7:0]         rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_prime_ff, rsp_prime_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic [P_W-1:0]     p_cand;
   logic [BLKQ_W-1:0]  q_low;
   logic [M_W-1:0]     r_low;
   logic [BLKQ_W-1:0]  q_cnt;
   logic [BLKQ_W-1:0]  rd_sel_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic [7:0]         wr_data;
   logic               wr_en;
   logic [3:0]         slot;
   logic [7:0]         clr_mask;
   logic               q_prime;

   // candidate base prime from its block and wheel slot
   assign p_cand = P_W'(({4'd0, pb_ff} * 10'd30) + {5'd0, res_of(pj_ff)});

   // divide by 30, second stage: fix the one-low quotient
   always_comb begin
      q_low = prod_ff[PROD_W-1 -: BLKQ_W];
      r_low = {1'b0, x_ff} - (M_W'(q_low) * M_W'(30));
   end

   assign slot = slot_of(r_ff);
   assign clr_mask = (slot == SLOT_NONE) ? 8'h00 : (8'h01 << slot[2:0]);
   assign q_cnt = q_ff + 1'b1;

   // memory ports
   assign rd_sel_addr = (cmd.rd_sel == RD_PB) ? {{(BLKQ_W-PB_W){1'b0}}, pb_ff} : q_ff;
   assign rd_addr = rd_sel_addr[ADDR_W-1:0];
   assign wr_en   = cmd.fill_en | cmd.mult_clear;
   assign wr_addr = cmd.fill_en ? fill_ff[ADDR_W-1:0] : q_ff[ADDR_W-1:0];
   assign wr_data = cmd.fill_en ? ((fill_ff == '0) ? 8'hFE : 8'hFF) : (rd_ff & ~clr_mask);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wheel_mem[wr_addr] <= wr_data;
      end
      rd_ff <= wheel_mem[rd_addr];
   end

   // query answer from the read byte
   always_comb begin
      if (num_ff inside {20'd2, 20'd3, 20'd5}) begin
         q_prime = 1'b1;
      end else if (slot == SLOT_NONE) begin
         q_prime = 1'b0;
      end else begin
         q_prime = rd_ff[slot[2:0]];
      end
   end

   // next values of the datapath registers
   always_comb begin
      limit_in       = csr_wr_en ? csr_wr_data : limit_ff;
      num_in         = cmd.req_load ? req_number : num_ff;
      built_limit_in = cmd.build_done ? lim_ff : built_limit_ff;
      built_flag_in  = built_flag_ff | cmd.build_done;
      lim_in  = lim_ff;
      nblk_in = nblk_ff;
      fill_in = fill_ff;
      pb_in   = pb_ff;
      pj_in   = pj_ff;
      p_in    = p_ff;
      sq_in   = sq_ff;
      m_in    = m_ff;
      g_in    = g_ff;

      // divider, first stage: operand and reciprocal product
      case (cmd.div_sel)
         DIV_LIM:  x_in = limit_ff;
         DIV_MULT: x_in = m_ff[LIMIT_W-1:0];
         default:  x_in = num_ff;
      endcase
      prod_in = PROD_W'(x_in) * PROD_W'(RECIP30);
      if (r_low >= M_W'(30)) begin
         q_in = q_low + 1'b1;
         r_in = 5'(r_low - M_W'(30));
      end else begin
         q_in = q_low;
         r_in = r_low[4:0];
      end

      // size the store from the limit, saturating at its depth
      if (cmd.size_load) begin
         nblk_in = (q_cnt > EFF_CNT) ? EFF_CNT : q_cnt;
         lim_in  = (LIMIT_W'(nblk_in) * LIMIT_W'(30)) - LIMIT_W'(1);
         fill_in = '0;
      end
      if (cmd.fill_en) begin
         fill_in = fill_ff + 1'b1;
      end
      // walk the base primes, starting at seven
      if (cmd.prime_init) begin
         pb_in = '0;
         pj_in = 3'd1;
      end
      if (cmd.prime_load) begin
         p_in  = p_cand;
         sq_in = SQ_W'(p_cand) * SQ_W'(p_cand);
      end
      if (cmd.prime_next) begin
         pj_in = pj_ff + 1'b1;
         if (pj_ff == 3'd7) begin
            pb_in = pb_ff + 1'b1;
         end
      end
      // step the multiple along the wheel
      if (cmd.mult_init) begin
         m_in = {1'b0, sq_ff};
         g_in = pj_ff;
      end
      if (cmd.mult_clear) begin
         m_in = m_ff + (M_W'(gap_of(g_ff)) * M_W'(p_ff));
         g_in = g_ff + 1'b1;
      end

      // result register: free once empty or being taken
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_prime_in  = rsp_prime_ff;
      rsp_status_in = rsp_status_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         if (cmd.rsp_build) begin
            rsp_prime_in  = 1'b0;
            rsp_status_in = ST_OK;
         end else if (!built_flag_ff) begin
            rsp_prime_in  = 1'b0;
            rsp_status_in = ST_NOBUILD;
         end else if (num_ff > built_limit_ff) begin
            rsp_prime_in  = 1'b0;
            rsp_status_in = ST_RANGE;
         end else begin
            rsp_prime_in  = q_prime;
            rsp_status_in = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff       <= LIMIT_RESET;
         built_limit_ff <= '0;
         built_flag_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         limit_ff       <= limit_in;
         built_limit_ff <= built_limit_in;
         built_flag_ff  <= built_flag_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      num_ff        <= num_in;
      lim_ff        <= lim_in;
      nblk_ff       <= nblk_in;
      fill_ff       <= fill_in;
      pb_ff         <= pb_in;
      pj_ff         <= pj_in;
      p_ff          <= p_in;
      sq_ff         <= sq_in;
      m_ff          <= m_in;
      g_ff          <= g_in;
      x_ff          <= x_in;
      prod_ff       <= prod_in;
      q_ff          <= q_in;
      r_ff          <= r_in;
      rsp_prime_ff  <= rsp_prime_in;
      rsp_status_ff <= rsp_status_in;
   end

   // status back to the sequencer
   assign stat.fill_last = (fill_ff == (nblk_ff - 1'b1));
   assign stat.sq_over   = (sq_ff > lim_ff);
   assign stat.prime_bit = rd_ff[pj_ff];
   assign stat.m_over    = (m_ff > {1'b0, lim_ff});
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_prime  = rsp_prime_ff;
   assign rsp_status = rsp_status_ff;

   `WSIEVE_ASSERT_NOW(a_load_free, cmd.rsp_load, stat.rsp_free)
   `WSIEVE_ASSERT_NOW(a_clear_in_range, cmd.mult_clear, m_ff <= {1'b0, lim_ff})
   `WSIEVE_ASSERT_NOW(a_fill_in_range, cmd.fill_en, fill_ff < nblk_ff)
   `WSIEVE_ASSERT_NEXT(a_built_sticky, built_flag_ff, built_flag_ff)

endmodule

`default_nettype wire

[src/wheel30_segmented_prime_sieve_unit.sv]
// Top level of the wheel-30 prime sieve: build a sieve, then answer primality queries.
// Depends on wsieve_pkg, wsieve_ctrl and wsieve_dp.
//
//   port group   direction   handshake             contents
//   req_*        in          req_valid/req_stall   mode, number
//   rsp_*        out         rsp_valid/rsp_stall   prime flag, status
//   csr_*        in          csr_wr_en             sieve_limit
//
// A query word passes two divide-by-30 stages, one registered store read and one
// result load that waits for a free result register; the next word is taken after it.
// A build word sizes the store, fills it block by block, then loads and checks each
// base-prime candidate, then divides, reads and clears each sieving prime's multiples.
// Reset is synchronous and clears the sequencer, the result register and the built flag.
// A stalled result holds; the next request word is taken meanwhile.
`default_nettype none

module wheel30_segmented_prime_sieve_unit
   import wsieve_pkg::*;
#(
   parameter int unsigned WHEEL_BLOCKS = 32768
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_mode,
   input  wire logic [LIMIT_W-1:0] req_number,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_prime,
   output logic [1:0]              rsp_status,
   input  wire logic               csr_wr_en,
   input  wire logic [LIMIT_W-1:0] csr_wr_data
);

   wsieve_cmd_type  cmd;
   wsieve_stat_type stat;

   wsieve_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   wsieve_dp #(
      .WHEEL_BLOCKS (WHEEL_BLOCKS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_number   (req_number),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_prime    (rsp_prime),
      .rsp_status   (rsp_status)
   );

endmodule

`default_nettype wire

[tb/tb_wheel30_segmented_prime_sieve_unit.sv]
// Self-checking testbench of the wheel-30 prime sieve: builds at several limits, then
// checks random and corner-case primality query words against a behavioral sieve.
// Depends on wsieve_pkg and wheel30_segmented_prime_sieve_unit.
`default_nettype none

module tb_wheel30_segmented_prime_sieve_unit;
   import wsieve_pkg::*;

   localparam int unsigned STORE_BLOCKS = 32768;
   localparam longint      CYCLE_LIMIT  = 20000000;

   // predicted sieve: its own store, limit register and built state
   class sieve_scoreboard;
      typedef struct packed {
         logic       prime_flag;
         logic [1:0] status;
      } verdict_type;

      bit [7:0]          wheel[STORE_BLOCKS];
      logic [LIMIT_W-1:0] limit_reg;
      logic [LIMIT_W-1:0] built_lim;
      bit                built;
      verdict_type       pending[$];
      int                errors;
      int unsigned       gaps[8];
      int unsigned       residues[8];

      function new();
         limit_reg = LIMIT_RESET;
         built_lim = '0;
         built     = 0;
         errors    = 0;
         gaps      = '{6, 4, 2, 4, 2, 4, 6, 2};
         residues  = '{1, 7, 11, 13, 17, 19, 23, 29};
      endfunction

      function void set_limit(logic [LIMIT_W-1:0] v);
         limit_reg = v;
      endfunction

      // wheel slot of a residue, 8 when not coprime to 30
      function int slot_of_res(int unsigned r);
         int s;
         s = 8;
         for (int j = 0; j < 8; j++)
            if (residues[j] == r) s = j;
         return s;
      endfunction

      function bit wheel_get(longint unsigned n);
         longint unsigned blk;
         int s;
         blk = n / 30;
         s = slot_of_res(n % 30);
         if (s >= 8 || blk >= STORE_BLOCKS) return 0;
         return wheel[blk][s];
      endfunction

      function void wheel_clear(longint unsigned n);
         longint unsigned blk;
         int s;
         blk = n / 30;
         s = slot_of_res(n % 30);
         if (s < 8 && blk < STORE_BLOCKS) wheel[blk][s] = 1'b0;
      endfunction

      // rebuild the sieve up to the rounded, saturated limit
      function void rebuild();
         longint unsigned lim, blocks, p, m;
         int g;
         bit stop;
         blocks = limit_reg / 30 + 1;
         if (blocks > STORE_BLOCKS) blocks = STORE_BLOCKS;
         lim = blocks * 30 - 1;
         for (longint unsigned b = 0; b < blocks; b++) wheel[b] = 8'hFF;
         wheel_clear(1);
         stop = 0;
         for (longint unsigned b = 0; b < blocks && !stop; b++) begin
            for (int j = 0; j < 8 && !stop; j++) begin
               p = b * 30 + residues[j];
               if (p < 7) continue;
               if (p * p > lim) begin
                  stop = 1;
                  continue;
               end
               if (!wheel_get(p)) continue;
               m = p * p;
               g = j;
               while (m <= lim) begin
                  wheel_clear(m);
                  m += gaps[g] * p;
                  g = (g + 1) & 7;
               end
            end
         end
         built_lim = lim[LIMIT_W-1:0];
         built     = 1;
      endfunction

      // note an accepted request word and queue its verdict
      function void note_request(logic mode, logic [LIMIT_W-1:0] number);
         verdict_type v;
         v = '{prime_flag: 1'b0, status: ST_OK};
         if (mode == MODE_BUILD) rebuild();
         else if (!built) v.status = ST_NOBUILD;
         else if (number > built_lim) v.status = ST_RANGE;
         else if (number == 2 || number == 3 || number == 5) v.prime_flag = 1'b1;
         else v.prime_flag = wheel_get(number);
         pending = {pending, v};
      endfunction

      // compare an accepted result word with the oldest verdict
      function void check_result(logic got_prime, logic [1:0] status);
         verdict_type v;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result word prime=%0d status=%0d",
                     $time, got_prime, status);
            errors++;
            return;
         end
         v = pending.pop_front();
         if (got_prime !== v.prime_flag) begin
            $display("%0t: prime flag expected %0d actual %0d",
                     $time, v.prime_flag, got_prime);
            errors++;
         end
         if (status !== v.status) begin
            $display("%0t: status expected %0d actual %0d", $time, v.status, status);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_mode = 1'b1;
   logic [LIMIT_W-1:0] req_number = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_prime;
   logic [1:0]         rsp_status;
   logic               csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   sieve_scoreboard sb = new();
   longint cycles = 0;
   int  stall_style = 0;     // 0 never, 1 random, 2 periodic
   bit  long_hold_go = 0;
   int  hold_left = 0;
   bit  no_gaps = 0;
   int  burst_left = 1;

   wheel30_segmented_prime_sieve_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_number(req_number),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_prime(rsp_prime), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #1 clock = ~clock;

   // abort on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // check result words and drive the receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_prime, rsp_status);
      if (long_hold_go && hold_left == 0) begin
         long_hold_go <= 0;
         hold_left <= 400;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= (hold_left > 1);
      end else begin
         case (stall_style)
            1: rsp_stall <= ($urandom_range(0, 99) < 35);
            2: rsp_stall <= ((cycles % 11) < 4);
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // offer one word, hold until accepted, then maybe drop into a gap
   task automatic send_word(logic mode, logic [LIMIT_W-1:0] number);
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_number <= number;
      do @(posedge clock); while (req_stall);
      sb.note_request(mode, number);
      burst_left--;
      if (burst_left <= 0 && !no_gaps) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 20);
      end
   endtask

   // wait until every result is back and the block has settled
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.set_limit(v);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [LIMIT_W-1:0] lim, n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // queries ahead of any build are flagged
      send_word(MODE_QUERY, 20'd0);
      send_word(MODE_QUERY, 20'hFFFFF);
      send_word(MODE_QUERY, 20'd7);
      drain_results();

      // smallest limit rounds up to one block
      write_limit(20'd0);
      send_word(MODE_BUILD, 20'hFFFFF);
      foreach (sb.residues[j]) send_word(MODE_QUERY, LIMIT_W'(sb.residues[j]));
      send_word(MODE_QUERY, 20'd0);
      send_word(MODE_QUERY, 20'd2);
      send_word(MODE_QUERY, 20'd3);
      send_word(MODE_QUERY, 20'd4);
      send_word(MODE_QUERY, 20'd5);
      send_word(MODE_QUERY, 20'd30);
      drain_results();

      // limit change after a build does not move the built limit
      write_limit(20'd100);
      send_word(MODE_BUILD, 20'd0);
      send_word(MODE_QUERY, 20'd49);
      send_word(MODE_QUERY, 20'd119);
      send_word(MODE_QUERY, 20'd120);
      drain_results();
      write_limit(20'd5000);
      send_word(MODE_QUERY, 20'd113);
      send_word(MODE_QUERY, 20'd200);
      drain_results();

      // random phases, two of them at the full store depth
      for (int ph = 0; ph < 12; ph++) begin
         stall_style = ph % 3;
         if (ph == 5) lim = 20'hFFFFF;
         else if (ph == 9) lim = 20'd983039;
         else lim = LIMIT_W'($urandom_range(0, 20000));
         write_limit(lim);
         send_word(MODE_BUILD, LIMIT_W'($urandom));
         if (ph == 2) begin
            // long receiver hold while words keep coming
            no_gaps = 1;
            long_hold_go = 1;
            repeat (40) send_word(MODE_QUERY, LIMIT_W'($urandom_range(0, lim)));
            no_gaps = 0;
         end
         for (int i = 0; i < 105; i++) begin
            case ($urandom_range(0, 19))
               0: n = LIMIT_W'($urandom);
               1: n = sb.built_lim + LIMIT_W'($urandom_range(0, 3));
               default: n = LIMIT_W'($urandom_range(0, sb.built_lim));
            endcase
            if (ph != 5 && ph != 9 && $urandom_range(0, 49) == 0)
               send_word(MODE_BUILD, LIMIT_W'($urandom));
            else
               send_word(MODE_QUERY, n);
         end
         drain_results();
      end

      if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire
